// ===== hw/rtl/efc_pkg.sv =====
// Shared types, constants and header classification for the Ethernet frame classifier.
package efc_pkg;

  localparam int POS_LIMIT = 2047;
  localparam int POS_W     = $clog2(POS_LIMIT + 1);

  localparam logic [15:0] TYPE_LEN_MAX = 16'h05FE;
  localparam logic [15:0] LLC_RAW      = 16'hFFFF;
  localparam logic [15:0] LLC_SNAP     = 16'hAAAA;
  localparam logic [15:0] ETH_IPV4     = 16'h0800;
  localparam logic [15:0] ETH_ARP      = 16'h0806;
  localparam logic [15:0] LLC_IPV4     = 16'h0606;
  localparam logic [15:0] LLC_STP      = 16'h4242;
  localparam logic [7:0]  IHL_MASK     = 8'h0F;

  localparam logic [4:0] BASE_II   = 5'd14;
  localparam logic [4:0] BASE_LLC  = 5'd17;
  localparam logic [4:0] BASE_SNAP = 5'd22;
  localparam logic [5:0] NEED_RAW  = 6'd16;
  localparam logic [5:0] LEN_IPV4  = 6'd20;
  localparam logic [5:0] LEN_ARP   = 6'd28;

  typedef enum logic [1:0] {
    FK_II   = 2'd0,
    FK_RAW  = 2'd1,
    FK_SNAP = 2'd2,
    FK_LLC  = 2'd3
  } frame_kind_t;

  typedef enum logic [1:0] {
    PK_OTHER = 2'd0,
    PK_IPV4  = 2'd1,
    PK_ARP   = 2'd2,
    PK_STP   = 2'd3
  } payload_kind_t;

  typedef logic [POS_W-1:0] pos_t;

  // Header bytes captured so far in the current frame.
  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [15:0] type_len;
    logic [15:0] llc_word;
    logic [15:0] snap_type;
    logic [7:0]  ver_ihl;
    logic [15:0] total_len;
    logic [7:0]  protocol;
    logic [31:0] addr_first;
    logic [31:0] addr_second;
  } hdr_t;

  typedef struct packed {
    frame_kind_t   fk;
    payload_kind_t pk;
    logic [4:0]    base;
    logic [5:0]    need;
  } cls_t;

  typedef struct packed {
    logic step;
    logic last;
  } step_t;

  typedef struct packed {
    frame_kind_t   frame_kind;
    payload_kind_t payload_kind;
    logic [47:0]   dest_mac;
    logic [47:0]   source_mac;
    logic [15:0]   type_or_length;
    logic [5:0]    ip_header_bytes;
    logic [15:0]   ip_total_length;
    logic [7:0]    ip_protocol;
    logic [31:0]   first_address;
    logic [31:0]   second_address;
    logic          truncated;
    logic [15:0]   frame_number;
  } rec_t;

  function automatic payload_kind_t type_kind(logic [15:0] t);
    payload_kind_t k;
    if (t == ETH_IPV4) begin
      k = PK_IPV4;
    end else if (t == ETH_ARP) begin
      k = PK_ARP;
    end else begin
      k = PK_OTHER;
    end
    return k;
  endfunction

  function automatic cls_t classify(hdr_t h);
    cls_t c;
    c = '0;
    if (h.type_len > TYPE_LEN_MAX) begin
      c.fk   = FK_II;
      c.base = BASE_II;
      c.pk   = type_kind(h.type_len);
    end else if (h.llc_word == LLC_RAW) begin
      c.fk   = FK_RAW;
      c.base = '0;
      c.pk   = PK_OTHER;
    end else if (h.llc_word == LLC_SNAP) begin
      c.fk   = FK_SNAP;
      c.base = BASE_SNAP;
      c.pk   = type_kind(h.snap_type);
    end else begin
      c.fk   = FK_LLC;
      c.base = BASE_LLC;
      if (h.llc_word == LLC_IPV4) begin
        c.pk = PK_IPV4;
      end else if (h.llc_word == LLC_STP) begin
        c.pk = PK_STP;
      end else begin
        c.pk = PK_OTHER;
      end
    end
    if (c.fk == FK_RAW) begin
      c.need = NEED_RAW;
    end else if (c.pk == PK_IPV4) begin
      c.need = {1'b0, c.base} + LEN_IPV4;
    end else if (c.pk == PK_ARP) begin
      c.need = {1'b0, c.base} + LEN_ARP;
    end else begin
      c.need = {1'b0, c.base};
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/efc_byte_if.sv =====
// Byte channel carrying frame bytes into the classifier.
interface efc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hw/rtl/efc_rec_if.sv =====
// Record channel carrying one classification result per frame.
interface efc_rec_if;
  logic                   valid;
  logic                   ready;
  efc_pkg::frame_kind_t   frame_kind;
  efc_pkg::payload_kind_t payload_kind;
  logic [47:0]            dest_mac;
  logic [47:0]            source_mac;
  logic [15:0]            type_or_length;
  logic [5:0]             ip_header_bytes;
  logic [15:0]            ip_total_length;
  logic [7:0]             ip_protocol;
  logic [31:0]            first_address;
  logic [31:0]            second_address;
  logic                   truncated;
  logic [15:0]            frame_number;

  modport source (
    output valid, output frame_kind, output payload_kind, output dest_mac,
    output source_mac, output type_or_length, output ip_header_bytes,
    output ip_total_length, output ip_protocol, output first_address,
    output second_address, output truncated, output frame_number,
    input ready
  );
  modport sink (
    input valid, input frame_kind, input payload_kind, input dest_mac,
    input source_mac, input type_or_length, input ip_header_bytes,
    input ip_total_length, input ip_protocol, input first_address,
    input second_address, input truncated, input frame_number,
    output ready
  );
endinterface

// ===== hw/rtl/efc_in_stage.sv =====
// Input register stage holding one frame byte until the parser takes it.
module efc_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  efc_byte_if.sink            in_ch,
  input  logic                out_free,
  output efc_pkg::step_t      step,
  output logic [7:0]          byte_q
);

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       advance;
  logic       accept;

  // A final byte waits for room in the record register; other bytes never stall.
  assign advance      = s1_valid_r && (!s1_last_r || out_free);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign accept       = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_ch.data_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

  assign step.step = advance;
  assign step.last = s1_last_r;
  assign byte_q    = s1_byte_r;

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_byte_r) && $stable(s1_last_r)))
    else $error("held byte changed while stalled");

  a_last_waits_for_room: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_last_r) |-> out_free)
    else $error("final byte advanced without room for its record");

endmodule

// ===== hw/rtl/efc_hdr_capture.sv =====
// Byte position tracking and header field capture for the current frame.
module efc_hdr_capture (
  input  logic              clk,
  input  logic              rst_n,
  input  efc_pkg::step_t    step,
  input  logic [7:0]        byte_q,
  output efc_pkg::hdr_t     hdr_nxt,
  output efc_pkg::pos_t     pos
);

  efc_pkg::hdr_t hdr_r;
  efc_pkg::pos_t pos_r;
  efc_pkg::pos_t pos_nxt;
  efc_pkg::cls_t cls;
  efc_pkg::pos_t rel;
  logic [2:0]    mac_idx;
  logic [2:0]    addr_idx;
  logic          addr_hit;

  always_comb begin
    hdr_nxt  = hdr_r;
    // Capture decisions only need header words that are complete before
    // this byte, so the stored header is classified.
    cls      = efc_pkg::classify(hdr_r);
    rel      = pos_r - efc_pkg::pos_t'(cls.base);
    mac_idx  = '0;
    addr_idx = '0;
    addr_hit = 1'b0;

    if (pos_r < efc_pkg::pos_t'(6)) begin
      mac_idx = 3'(3'd5 - pos_r[2:0]);
      hdr_nxt.dest_mac[{mac_idx, 3'b000} +: 8] = byte_q;
    end else if (pos_r < efc_pkg::pos_t'(12)) begin
      mac_idx = 3'(4'd11 - pos_r[3:0]);
      hdr_nxt.source_mac[{mac_idx, 3'b000} +: 8] = byte_q;
    end else if (pos_r == efc_pkg::pos_t'(12)) begin
      hdr_nxt.type_len[15:8] = byte_q;
    end else if (pos_r == efc_pkg::pos_t'(13)) begin
      hdr_nxt.type_len[7:0] = byte_q;
    end else if (hdr_r.type_len <= efc_pkg::TYPE_LEN_MAX) begin
      if (pos_r == efc_pkg::pos_t'(14)) begin
        hdr_nxt.llc_word[15:8] = byte_q;
      end else if (pos_r == efc_pkg::pos_t'(15)) begin
        hdr_nxt.llc_word[7:0] = byte_q;
      end else if (hdr_r.llc_word == efc_pkg::LLC_SNAP) begin
        if (pos_r == efc_pkg::pos_t'(20)) begin
          hdr_nxt.snap_type[15:8] = byte_q;
        end else if (pos_r == efc_pkg::pos_t'(21)) begin
          hdr_nxt.snap_type[7:0] = byte_q;
        end
      end
    end

    if (cls.base != '0 && pos_r >= efc_pkg::pos_t'(cls.base)) begin
      if (cls.pk == efc_pkg::PK_IPV4) begin
        if (rel == efc_pkg::pos_t'(0)) begin
          hdr_nxt.ver_ihl = byte_q;
        end else if (rel == efc_pkg::pos_t'(2)) begin
          hdr_nxt.total_len[15:8] = byte_q;
        end else if (rel == efc_pkg::pos_t'(3)) begin
          hdr_nxt.total_len[7:0] = byte_q;
        end else if (rel == efc_pkg::pos_t'(9)) begin
          hdr_nxt.protocol = byte_q;
        end else if (rel >= efc_pkg::pos_t'(12) && rel < efc_pkg::pos_t'(20)) begin
          // Source address bytes land at the top of the pair, destination below.
          addr_idx = 3'(5'd19 - rel[4:0]);
          addr_hit = 1'b1;
        end
      end else if (cls.pk == efc_pkg::PK_ARP) begin
        if (rel >= efc_pkg::pos_t'(14) && rel < efc_pkg::pos_t'(18)) begin
          addr_idx = 3'(5'd21 - rel[4:0]);
          addr_hit = 1'b1;
        end else if (rel >= efc_pkg::pos_t'(24) && rel < efc_pkg::pos_t'(28)) begin
          addr_idx = 3'(5'd27 - rel[4:0]);
          addr_hit = 1'b1;
        end
      end
    end

    if (addr_hit) begin
      if (addr_idx[2]) begin
        hdr_nxt.addr_first[{addr_idx[1:0], 3'b000} +: 8] = byte_q;
      end else begin
        hdr_nxt.addr_second[{addr_idx[1:0], 3'b000} +: 8] = byte_q;
      end
    end
  end

  assign pos_nxt = (pos_r >= efc_pkg::pos_t'(efc_pkg::POS_LIMIT)) ?
                   efc_pkg::pos_t'(efc_pkg::POS_LIMIT) : pos_r + efc_pkg::pos_t'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= '0;
      pos_r <= '0;
    end else if (step.step) begin
      if (step.last) begin
        hdr_r <= '0;
        pos_r <= '0;
      end else begin
        hdr_r <= hdr_nxt;
        pos_r <= pos_nxt;
      end
    end
  end

  assign pos = pos_r;

  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= efc_pkg::pos_t'(efc_pkg::POS_LIMIT))
    else $error("byte position beyond its limit");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step.step && step.last) |=> (pos_r == '0 && hdr_r == '0))
    else $error("frame state not cleared after final byte");

endmodule

// ===== hw/rtl/efc_rec_out.sv =====
// Frame classification, record assembly and the record output register.
module efc_rec_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              emit,
  input  efc_pkg::hdr_t     hdr_nxt,
  input  efc_pkg::pos_t     pos,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_free,
  output efc_pkg::rec_t     rec
);

  efc_pkg::cls_t           cls;
  efc_pkg::rec_t           rec_nxt;
  efc_pkg::rec_t           rec_r;
  logic                    out_valid_r;
  logic [15:0]             frame_cnt_r;
  logic [15:0]             frame_cnt_nxt;
  logic [efc_pkg::POS_W:0] len_seen;

  assign frame_cnt_nxt = frame_cnt_r + 16'd1;
  assign len_seen      = {1'b0, pos} + {{efc_pkg::POS_W{1'b0}}, 1'b1};

  always_comb begin
    cls                     = efc_pkg::classify(hdr_nxt);
    rec_nxt                 = '0;
    rec_nxt.frame_kind      = cls.fk;
    rec_nxt.payload_kind    = cls.pk;
    rec_nxt.dest_mac        = hdr_nxt.dest_mac;
    rec_nxt.source_mac      = hdr_nxt.source_mac;
    rec_nxt.type_or_length  = hdr_nxt.type_len;
    if (cls.pk == efc_pkg::PK_IPV4) begin
      rec_nxt.ip_header_bytes = {hdr_nxt.ver_ihl[3:0] & efc_pkg::IHL_MASK[3:0], 2'b00};
      rec_nxt.ip_total_length = hdr_nxt.total_len;
      rec_nxt.ip_protocol     = hdr_nxt.protocol;
    end
    if (cls.pk == efc_pkg::PK_IPV4 || cls.pk == efc_pkg::PK_ARP) begin
      rec_nxt.first_address  = hdr_nxt.addr_first;
      rec_nxt.second_address = hdr_nxt.addr_second;
    end
    rec_nxt.truncated    = len_seen < (efc_pkg::POS_W + 1)'(cls.need);
    rec_nxt.frame_number = frame_cnt_nxt;
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      frame_cnt_r <= '0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
      frame_cnt_r <= frame_cnt_nxt;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rec_r <= rec_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign rec       = rec_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_ready))
    else $error("record overwritten before it was taken");

  a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (frame_cnt_r == $past(frame_cnt_r) + 16'd1 && out_valid_r
              && rec_r.frame_number == frame_cnt_r))
    else $error("frame number did not advance by one with a record");

endmodule

// ===== hw/rtl/ethernet_frame_classifier.sv =====
// A record is registered as its frame's final byte leaves the input register.
// Throughput: one byte per cycle; bytes keep flowing while a record waits, and only
// a final byte stalls, in the input register, until the record register is free.
// Header capture is a position compare and byte select per cycle, with no loop.
// Reset (synchronous, active low) clears the byte position, all captured header
// fields, the frame counter and both valid flags.
module ethernet_frame_classifier (
  input  logic       clk,
  input  logic       rst_n,
  efc_byte_if.sink   in_ch,
  efc_rec_if.source  out_ch
);

  efc_pkg::step_t step;
  efc_pkg::hdr_t  hdr_nxt;
  efc_pkg::pos_t  pos;
  efc_pkg::rec_t  rec;
  logic [7:0]     byte_q;
  logic           out_free;

  efc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_free (out_free),
    .step     (step),
    .byte_q   (byte_q)
  );

  efc_hdr_capture u_hdr_capture (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_q  (byte_q),
    .hdr_nxt (hdr_nxt),
    .pos     (pos)
  );

  efc_rec_out u_rec_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (step.step && step.last),
    .hdr_nxt   (hdr_nxt),
    .pos       (pos),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_free  (out_free),
    .rec       (rec)
  );

  assign out_ch.frame_kind      = rec.frame_kind;
  assign out_ch.payload_kind    = rec.payload_kind;
  assign out_ch.dest_mac        = rec.dest_mac;
  assign out_ch.source_mac      = rec.source_mac;
  assign out_ch.type_or_length  = rec.type_or_length;
  assign out_ch.ip_header_bytes = rec.ip_header_bytes;
  assign out_ch.ip_total_length = rec.ip_total_length;
  assign out_ch.ip_protocol     = rec.ip_protocol;
  assign out_ch.first_address   = rec.first_address;
  assign out_ch.second_address  = rec.second_address;
  assign out_ch.truncated       = rec.truncated;
  assign out_ch.frame_number    = rec.frame_number;

endmodule
